// ===== hw/rtl/fdcf_pkg.sv =====
`timescale 1ns / 1ps

package fdcf_pkg;

  localparam int MAX_PAYLOAD = 32;
  localparam int IDX_W       = $clog2(MAX_PAYLOAD);
  localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);
  localparam int ADDR_W      = IDX_W + 1;   // bank bit above the payload index

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PAYLOAD);

  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] CRC_POLY  = 8'h07;
  localparam logic [7:0] LEN_ADJ   = 8'h02;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_CRC_SEED = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_CRC_FXOR = CFG_IDX_W'(1);

  localparam logic [7:0] CRC_SEED_RST = 8'h02;
  localparam logic [7:0] CRC_FXOR_RST = 8'h02;

  // One finished frame waiting in the queue
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             ovf;
  } desc_t;

  // Requests from the front into the queue
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
    logic              push;
    desc_t             desc;
  } wr_req_t;

  // CRC-8, polynomial 0x07, MSB first
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/flag_delimited_crc8_framer_unit.sv =====
`timescale 1ns / 1ps

// Flag-delimited CRC-8 framer.
// Input stream (s_*): one payload byte per request, s_tlast on the final byte
// of a telegram. While a buffer is free, bytes load at one per cycle into one
// of two 32-byte buffers; bytes past 32 are dropped, the frame marked overflowed.
// Output stream (m_*): 0x7E, length (count + 2), payload, CRC-8, 0x7E, with
// m_tlast on the closing flag and m_tuser set on every byte of an overflowed
// frame. CRC: poly 0x07, MSB first, from crc_seed over length and payload,
// XORed with crc_final_xor.
// Config channel (cfg_*): index 0 = crc_seed, 1 = crc_final_xor, always
// ready; write only while the block is idle.
// With the back idle, m_tvalid rises for the opening flag after the final
// byte's acceptance goes through the queue push, then the output register.
// A frame of n stored payload bytes gives n + 4 output bytes; the opening flag
// of a frame already waiting follows the closing flag directly.
// Throughput: input runs at one byte per cycle while a buffer is free; with
// two completed frames waiting, input holds until the older one's closing
// flag enters the output register.
// A stalled receiver holds the output register and back-pressures the input
// only through the buffer queue.
// Reset clears counters, queue and output valid; CRC registers return to 0x02.
module flag_delimited_crc8_framer_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,    // [7:0] payload_byte
  input  logic                              s_tlast,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [7:0]                        m_tdata,    // [7:0] frame_byte
  output logic                              m_tlast,
  output logic                              m_tuser,    // [0] overflow
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fdcf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [7:0]                        cfg_data
);
  import fdcf_pkg::*;

  logic              q_full;
  wr_req_t           wr_req;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;
  logic              desc_pop;
  desc_t             head;
  logic              head_valid;
  logic [7:0]        crc_seed;
  logic [7:0]        crc_final_xor;

  // config registers: take every request, ignore unknown indexes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_seed      <= CRC_SEED_RST;
      crc_final_xor <= CRC_FXOR_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CRC_SEED: crc_seed      <= cfg_data;
        CFG_CRC_FXOR: crc_final_xor <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // front: store bytes and hand finished frames to the queue
  fdcf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .wr_req   (wr_req)
  );

  // double buffer plus frame descriptor queue
  fdcf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .wr_req     (wr_req),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .pop        (desc_pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (q_full)
  );

  // back: walk the frame out byte by byte, accumulating CRC
  fdcf_back u_back (
    .clk           (clk),
    .rst           (rst),
    .crc_seed      (crc_seed),
    .crc_final_xor (crc_final_xor),
    .head          (head),
    .head_valid    (head_valid),
    .pop           (desc_pop),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tlast       (m_tlast),
    .m_tuser       (m_tuser)
  );

`ifndef SYNTHESIS
  a_end_is_flag: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tdata == FLAG_BYTE))
    else $error("closing byte is not a flag");

  a_pop_shows_end: assert property (@(posedge clk) disable iff (rst)
    desc_pop |=> (m_tvalid && m_tlast))
    else $error("descriptor released without closing flag");

  a_full_blocks_input: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !s_tready)
    else $error("input taken with both buffers owned");

  a_head_count_bound: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> (head.count <= CNT_MAX))
    else $error("frame count exceeds buffer size");
`endif

endmodule

// ===== hw/rtl/fdcf_front.sv =====
`timescale 1ns / 1ps

module fdcf_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,
  input  logic                s_tlast,
  input  logic                q_full,
  output fdcf_pkg::wr_req_t   wr_req
);
  import fdcf_pkg::*;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             ovf_seen;
  logic             ovf_next;
  logic             bank;
  logic             accept;
  logic             room;
  logic [CNT_W-1:0] count_after;
  logic             ovf_after;

  assign s_tready    = !q_full;
  assign accept      = s_tvalid && s_tready;
  assign room        = (count < CNT_MAX);
  assign count_after = room ? (count + CNT_W'(1)) : count;
  assign ovf_after   = ovf_seen || !room;

  always_comb begin
    wr_req.we         = accept && room;
    wr_req.addr       = {bank, count[IDX_W-1:0]};
    wr_req.data       = s_tdata;
    wr_req.push       = accept && s_tlast;
    wr_req.desc.count = count_after;
    wr_req.desc.ovf   = ovf_after;
    count_next = count;
    ovf_next   = ovf_seen;
    if (accept) begin
      count_next = s_tlast ? '0 : count_after;
      ovf_next   = s_tlast ? 1'b0 : ovf_after;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      ovf_seen <= 1'b0;
      bank     <= 1'b0;
    end else begin
      count    <= count_next;
      ovf_seen <= ovf_next;
      // swap to the other buffer once a frame is handed over
      if (wr_req.push) begin
        bank <= ~bank;
      end
    end
  end

endmodule

// ===== hw/rtl/fdcf_queue.sv =====
`timescale 1ns / 1ps

module fdcf_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  fdcf_pkg::wr_req_t           wr_req,
  input  logic [fdcf_pkg::ADDR_W-1:0] rd_addr,
  output logic [7:0]                  rd_data,
  input  logic                        pop,
  output fdcf_pkg::desc_t             head,
  output logic                        head_valid,
  output logic                        full
);
  import fdcf_pkg::*;

  localparam int MEM_DEPTH = 2 ** ADDR_W;

  logic [7:0] mem [0:MEM_DEPTH-1];
  desc_t      desc_q [0:1];
  logic       wptr;
  logic       rptr;
  logic [1:0] fill;

  always_ff @(posedge clk) begin
    if (wr_req.we) begin
      mem[wr_req.addr] <= wr_req.data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_req.push) begin
      desc_q[wptr] <= wr_req.desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (wr_req.push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      fill <= fill + 2'(wr_req.push) - 2'(pop);
    end
  end

  assign head       = desc_q[rptr];
  assign head_valid = (fill != 2'd0);
  assign full       = (fill == 2'd2);

endmodule

// ===== hw/rtl/fdcf_back.sv =====
`timescale 1ns / 1ps

module fdcf_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [7:0]                  crc_seed,
  input  logic [7:0]                  crc_final_xor,
  input  fdcf_pkg::desc_t             head,
  input  logic                        head_valid,
  output logic                        pop,
  output logic [fdcf_pkg::ADDR_W-1:0] rd_addr,
  input  logic [7:0]                  rd_data,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [7:0]                  m_tdata,
  output logic                        m_tlast,
  output logic                        m_tuser
);
  import fdcf_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LEN  = 3'd1;
  localparam logic [2:0] ST_PAY  = 3'd2;
  localparam logic [2:0] ST_CRC  = 3'd3;
  localparam logic [2:0] ST_END  = 3'd4;

  logic [2:0]       st;
  logic [2:0]       st_next;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] idx_next;
  logic [7:0]       crc;
  logic [7:0]       crc_next;
  logic             bank;
  logic             bank_next;
  logic             vld_next;
  logic [7:0]       data_next;
  logic             last_next;
  logic             user_next;
  logic             load;
  logic [7:0]       len;

  assign load = !m_tvalid || m_tready;
  assign len  = 8'(head.count) + LEN_ADJ;

  always_comb begin
    st_next   = st;
    idx_next  = idx;
    crc_next  = crc;
    bank_next = bank;
    pop       = 1'b0;
    vld_next  = m_tvalid && !m_tready;
    data_next = m_tdata;
    last_next = m_tlast;
    user_next = m_tuser;
    if (load) begin
      case (st)
        ST_IDLE: begin
          if (head_valid) begin
            vld_next  = 1'b1;
            data_next = FLAG_BYTE;
            last_next = 1'b0;
            user_next = head.ovf;
            st_next   = ST_LEN;
          end
        end
        ST_LEN: begin
          vld_next  = 1'b1;
          data_next = len;
          crc_next  = crc8_update(crc_seed, len);
          st_next   = (head.count == '0) ? ST_CRC : ST_PAY;
        end
        ST_PAY: begin
          vld_next  = 1'b1;
          data_next = rd_data;
          crc_next  = crc8_update(crc, rd_data);
          idx_next  = idx + CNT_W'(1);
          if (idx_next == head.count) begin
            st_next = ST_CRC;
          end
        end
        ST_CRC: begin
          vld_next  = 1'b1;
          data_next = crc ^ crc_final_xor;
          st_next   = ST_END;
        end
        ST_END: begin
          vld_next  = 1'b1;
          data_next = FLAG_BYTE;
          last_next = 1'b1;
          pop       = 1'b1;
          bank_next = ~bank;
          idx_next  = '0;
          st_next   = ST_IDLE;
        end
        default: begin
          st_next = ST_IDLE;
        end
      endcase
    end
  end

  // address the next byte so the registered read lines up with idx
  assign rd_addr = {bank_next, idx_next[IDX_W-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= ST_IDLE;
      idx      <= '0;
      bank     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      st       <= st_next;
      idx      <= idx_next;
      bank     <= bank_next;
      m_tvalid <= vld_next;
    end
  end

  always_ff @(posedge clk) begin
    crc     <= crc_next;
    m_tdata <= data_next;
    m_tlast <= last_next;
    m_tuser <= user_next;
  end

endmodule

// ===== bench/crc8_frame_checker.sv =====
`timescale 1ns / 1ps

module crc8_frame_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [7:0]                     s_tdata,
  input  logic                           s_tlast,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [7:0]                     m_tdata,
  input  logic                           m_tlast,
  input  logic                           m_tuser,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [fdcf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data,
  output int                             fails,
  output int                             outstanding
);

  typedef struct packed {
    logic [7:0] data;
    logic       closing;
    logic       ovf;
  } frame_byte_t;

  logic [7:0]  payload_mem [fdcf_pkg::MAX_PAYLOAD];
  int          held_count;
  logic        dropped;
  logic [7:0]  seed_reg;
  logic [7:0]  fxor_reg;
  frame_byte_t frame_bytes_q[$];
  int          reports;

  // Shift one data bit at a time into the CRC register, MSB first
  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] r;
    logic       fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[7] ^ data[i];
      r  = {r[6:0], 1'b0} ^ (fb ? fdcf_pkg::CRC_POLY : 8'h00);
    end
    return r;
  endfunction

  function automatic void push_byte(input logic [7:0] data, input logic closing);
    frame_byte_t fb;
    fb.data    = data;
    fb.closing = closing;
    fb.ovf     = dropped;
    frame_bytes_q.push_back(fb);
  endfunction

  // Store or drop one payload byte; on the last one lay out the whole frame
  function automatic void take_payload(input logic [7:0] data, input logic last);
    logic [7:0] len;
    logic [7:0] crc;
    if (held_count < fdcf_pkg::MAX_PAYLOAD) begin
      payload_mem[held_count] = data;
      held_count++;
    end else begin
      dropped = 1'b1;
    end
    if (!last) return;
    len = 8'(held_count) + fdcf_pkg::LEN_ADJ;
    push_byte(fdcf_pkg::FLAG_BYTE, 1'b0);
    push_byte(len, 1'b0);
    crc = crc8_next(seed_reg, len);
    for (int i = 0; i < held_count; i++) begin
      push_byte(payload_mem[i], 1'b0);
      crc = crc8_next(crc, payload_mem[i]);
    end
    push_byte(crc ^ fxor_reg, 1'b0);
    push_byte(fdcf_pkg::FLAG_BYTE, 1'b1);
    held_count = 0;
    dropped    = 1'b0;
  endfunction

  function automatic void check_frame_byte();
    frame_byte_t want;
    if (frame_bytes_q.size() == 0) begin
      fails++;
      if (reports < 10)
        $display("%0t: unexpected frame byte %02h last %0b ovf %0b",
                 $realtime, m_tdata, m_tlast, m_tuser);
      reports++;
      return;
    end
    want = frame_bytes_q.pop_front();
    if (want.data !== m_tdata || want.closing !== m_tlast || want.ovf !== m_tuser) begin
      fails++;
      if (reports < 10)
        $display("%0t: frame byte mismatch: expected %02h last %0b ovf %0b, got %02h last %0b ovf %0b",
                 $realtime, want.data, want.closing, want.ovf, m_tdata, m_tlast, m_tuser);
      reports++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      held_count = 0;
      dropped    = 1'b0;
      seed_reg   = fdcf_pkg::CRC_SEED_RST;
      fxor_reg   = fdcf_pkg::CRC_FXOR_RST;
      frame_bytes_q.delete();
    end else begin
      if (m_tvalid && m_tready) check_frame_byte();
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          fdcf_pkg::CFG_CRC_SEED: seed_reg = cfg_data;
          fdcf_pkg::CFG_CRC_FXOR: fxor_reg = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) take_payload(s_tdata, s_tlast);
    end
    outstanding <= frame_bytes_q.size();
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int PHASE_ITEMS  = 60;
  localparam int SETTLE_CYCLE = 6;

  logic                           clk;
  logic                           rst;
  logic                           s_tvalid;
  logic                           s_tready;
  logic [7:0]                     s_tdata;    // [7:0] payload_byte
  logic                           s_tlast;
  logic                           m_tvalid;
  logic                           m_tready;
  logic [7:0]                     m_tdata;    // [7:0] frame_byte
  logic                           m_tlast;
  logic                           m_tuser;    // [0] overflow
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [fdcf_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [7:0]                     cfg_data;

  int   fails;
  int   outstanding;
  int   cycle_count = 0;
  int   frame_count = 0;
  int   big_pick    = 0;
  logic burst       = 1'b0;

  flag_delimited_crc8_framer_unit uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Watch all three channels, predict every frame byte and compare
  crc8_frame_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .m_tuser     (m_tuser),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fails       (fails),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL flag_delimited_crc8_framer_unit");
      $finish;
    end
  end

  // Idle length for either side: mostly none or short, now and then long
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // Receiver: alternate ready stretches with stalls, some stretches long and clean
  initial begin
    int run;
    int hold;
    m_tready = 1'b0;
    @(negedge clk);
    forever begin
      run = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 12);
      m_tready <= 1'b1;
      repeat (run) @(negedge clk);
      hold = idle_cycles();
      if (hold > 0) begin
        m_tready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
    end
  end

  // Offer one payload byte after an optional gap and hold it until the request is taken
  task automatic send_payload(input logic [7:0] data, input logic last);
    int gap;
    gap = burst ? 0 : idle_cycles();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tlast  <= last;
    @(posedge clk);
    while (!(s_tvalid && s_tready)) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop valid, wait for every predicted byte, then let the output register settle
  task automatic drain_frames();
    s_tvalid <= 1'b0;
    wait (outstanding == 0);
    @(negedge clk);
    repeat (SETTLE_CYCLE) @(negedge clk);
  endtask

  task automatic write_crc_regs(input logic [7:0] seed, input logic [7:0] fxor);
    cfg_valid <= 1'b1;
    cfg_index <= fdcf_pkg::CFG_CRC_SEED;
    cfg_data  <= seed;
    @(posedge clk);
    while (!(cfg_valid && cfg_ready)) @(posedge clk);
    @(negedge clk);
    cfg_index <= fdcf_pkg::CFG_CRC_FXOR;
    cfg_data  <= fxor;
    @(posedge clk);
    while (!(cfg_valid && cfg_ready)) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random frames with random bytes; every sixth frame fills or overruns the store
  task automatic run_phase(input int items);
    int done;
    int n;
    done = 0;
    while (done < items) begin
      frame_count++;
      burst = ($urandom_range(0, 4) == 0);
      if (frame_count % 6 == 0) begin
        case (big_pick % 3)
          0:       n = fdcf_pkg::MAX_PAYLOAD + 1;   // last byte itself is dropped
          1:       n = fdcf_pkg::MAX_PAYLOAD;       // store exactly full
          default: n = $urandom_range(fdcf_pkg::MAX_PAYLOAD + 2, fdcf_pkg::MAX_PAYLOAD + 13);
        endcase
        big_pick++;
      end else if ($urandom_range(0, 9) < 7) begin
        n = $urandom_range(1, 6);
      end else begin
        n = $urandom_range(7, fdcf_pkg::MAX_PAYLOAD - 1);
      end
      for (int i = 0; i < n; i++)
        send_payload(8'($urandom_range(0, 255)), i == n - 1);
      done += n;
    end
    burst = 1'b0;
  endtask

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = 8'h00;
    s_tlast   = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = fdcf_pkg::CFG_CRC_SEED;
    cfg_data  = 8'h00;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset CRC settings: single-byte frames at both byte extremes, flag value
    // inside the payload (no stuffing), then a two-byte frame
    send_payload(8'h00, 1'b1);
    send_payload(8'hFF, 1'b1);
    send_payload(8'h7E, 1'b0);
    send_payload(8'h55, 1'b0);
    send_payload(8'hAA, 1'b0);
    send_payload(8'h01, 1'b0);
    send_payload(8'h80, 1'b1);
    send_payload(8'h00, 1'b0);
    send_payload(8'hFF, 1'b1);
    drain_frames();

    // Seed and final xor at their low extreme
    write_crc_regs(8'h00, 8'h00);
    send_payload(8'h00, 1'b1);
    send_payload(8'hFF, 1'b0);
    send_payload(8'h7E, 1'b1);
    drain_frames();

    // Both at their high extreme
    write_crc_regs(8'hFF, 8'hFF);
    send_payload(8'hFF, 1'b1);
    send_payload(8'h00, 1'b0);
    send_payload(8'h80, 1'b1);
    drain_frames();

    // Random part: mixed extremes first, then random settings
    write_crc_regs(8'hFF, 8'h00);
    run_phase(PHASE_ITEMS);
    drain_frames();
    write_crc_regs(8'h00, 8'hFF);
    run_phase(PHASE_ITEMS);
    drain_frames();
    for (int p = 0; p < 3; p++) begin
      write_crc_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      run_phase(PHASE_ITEMS);
      drain_frames();
    end

    // Catch any stray bytes after the last frame
    repeat (20) @(negedge clk);
    if (fails == 0) begin
      $display("PASS flag_delimited_crc8_framer_unit");
    end else begin
      $display("FAIL flag_delimited_crc8_framer_unit");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/fdcf_pkg.sv
hw/rtl/fdcf_front.sv
hw/rtl/fdcf_queue.sv
hw/rtl/fdcf_back.sv
hw/rtl/flag_delimited_crc8_framer_unit.sv
bench/crc8_frame_checker.sv
bench/tb_top.sv
